/* src/srom_pkg.sv */
// Shared types and codes for the slot range owner map.
// Used by srom_ctrl, srom_dpath and slot_range_owner_map; depends on nothing.

package srom_pkg;

    // Field widths fixed by the request and result formats
    localparam int SLOT_W      = 16;
    localparam int GROUP_W     = 16;
    localparam int STATUS_W    = 3;
    localparam int CONFLICT_W  = 14;
    localparam int COUNT_W     = 15;
    localparam int REQ_W       = 2;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (STATUS_W + 1 + GROUP_W + CONFLICT_W + COUNT_W);

    localparam logic [GROUP_W-1:0] OUT_NONE = '1;

    typedef logic [REQ_W-1:0]    req_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [1:0]          res_kind_t;

    // Request kinds
    localparam req_t REQ_CLEAR  = 2'd0;
    localparam req_t REQ_ASSIGN = 2'd1;
    localparam req_t REQ_LOOKUP = 2'd2;

    // Result status codes
    localparam status_t ST_OK         = 3'd0;
    localparam status_t ST_INVERTED   = 3'd1;
    localparam status_t ST_BEYOND     = 3'd2;
    localparam status_t ST_OWNED      = 3'd3;
    localparam status_t ST_FAILED     = 3'd4;
    localparam status_t ST_LOOKUP_OOR = 3'd5;

    // Where the result fields come from
    localparam res_kind_t RES_PLAIN    = 2'd0;
    localparam res_kind_t RES_LOOKUP   = 2'd1;
    localparam res_kind_t RES_CONFLICT = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic      latch_req;
        logic      rd_first;
        logic      walk_start;
        logic      walk_step;
        logic      clr_write;
        logic      clear_state;
        logic      set_fail;
        logic      set_res;
        res_kind_t res_kind;
        status_t   res_status;
        logic      out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        req_t req_type;
        logic failed;
        logic inverted;
        logic beyond;
        logic no_owner_grp;
        logic lookup_oor;
        logic clr_last;
        logic entry_owned;
        logic walk_last;
        logic out_busy;
    } sts_t;

endpackage

/* src/srom_ctrl.sv */
// Sequencer for the slot range owner map: reset sweep, decode, lookup, walk, clear, respond.
// Depends on srom_pkg for the command and status structs and the codes.

module srom_ctrl
    import srom_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_LOOKUP = 3'd3;
    localparam logic [2:0] S_WALK   = 3'd4;
    localparam logic [2:0] S_CLEAR  = 3'd5;
    localparam logic [2:0] S_RESP   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.set_res    = 1'b1;
                cmd.res_kind   = RES_PLAIN;
                cmd.res_status = ST_OK;
                state_next     = S_RESP;
                unique case (sts.req_type)
                    REQ_CLEAR:
                    begin
                        cmd.clear_state = 1'b1;
                        state_next      = S_CLEAR;
                    end
                    REQ_ASSIGN:
                    begin
                        if (sts.failed)
                        begin
                            cmd.res_status = ST_FAILED;
                        end
                        else if (sts.inverted)
                        begin
                            cmd.res_status = ST_INVERTED;
                            cmd.set_fail   = 1'b1;
                        end
                        else if (sts.beyond)
                        begin
                            cmd.res_status = ST_BEYOND;
                            cmd.set_fail   = 1'b1;
                        end
                        else if (!sts.no_owner_grp)
                        begin
                            cmd.set_res    = 1'b0;
                            cmd.rd_first   = 1'b1;
                            cmd.walk_start = 1'b1;
                            state_next     = S_WALK;
                        end
                    end
                    REQ_LOOKUP:
                    begin
                        if (sts.failed)
                        begin
                            cmd.res_status = ST_FAILED;
                        end
                        else if (sts.lookup_oor)
                        begin
                            cmd.res_status = ST_LOOKUP_OOR;
                        end
                        else
                        begin
                            cmd.set_res  = 1'b0;
                            cmd.rd_first = 1'b1;
                            state_next   = S_LOOKUP;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_LOOKUP:
            begin
                cmd.set_res    = 1'b1;
                cmd.res_kind   = RES_LOOKUP;
                cmd.res_status = ST_OK;
                state_next     = S_RESP;
            end
            S_WALK:
            begin
                if (sts.entry_owned)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_kind   = RES_CONFLICT;
                    cmd.res_status = ST_OWNED;
                    cmd.set_fail   = 1'b1;
                    state_next     = S_RESP;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    if (sts.walk_last)
                    begin
                        cmd.set_res    = 1'b1;
                        cmd.res_kind   = RES_PLAIN;
                        cmd.res_status = ST_OK;
                        state_next     = S_RESP;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_init_sweep_done: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == S_INIT && state_reg != S_INIT) |-> $past(sts.clr_last))
        else $error("left reset sweep before the last table entry");

    a_walk_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK || state_reg == S_CLEAR) |-> !cmd.latch_req)
        else $error("request latched during a walk or clear");

endmodule

/* src/srom_dpath.sv */
// Datapath of the slot range owner map: owner table memory, walk pointer,
// count, failure flag, result and output registers. Depends on srom_pkg.

module srom_dpath
    import srom_pkg::*;
#(
    parameter int SLOT_COUNT        = 16384,
    parameter int GROUP_INDEX_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  in_tdata,
    input  req_t                   in_tuser,
    input  logic                   out_tready,
    output logic                   out_tvalid,
    output logic [OUT_TDATA_W-1:0] out_tdata,
    input  cmd_t                   cmd,
    output sts_t                   sts
);

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int GW = GROUP_INDEX_WIDTH;
    localparam logic [SLOT_W:0]   SLOT_LIMIT = (SLOT_W + 1)'(SLOT_COUNT);
    localparam logic [AW-1:0]     LAST_ADDR  = AW'(SLOT_COUNT - 1);
    localparam logic [GW-1:0]     NO_OWNER   = '1;

    // Latched request
    req_t              req_type_reg;
    logic [SLOT_W-1:0] first_reg;
    logic [SLOT_W-1:0] last_reg;
    logic [GW-1:0]     group_reg;

    // Table and walk
    logic [GW-1:0]     owner_mem [SLOT_COUNT];
    logic [GW-1:0]     rd_data_reg;
    logic [AW-1:0]     clr_addr_reg;
    logic [SLOT_W-1:0] chk_reg;
    logic [SLOT_W-1:0] chk_plus;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [GW-1:0]     wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    // Bookkeeping
    logic [COUNT_W-1:0] covered_reg;
    logic               failed_reg;

    // Result staging and output register
    status_t               res_status_reg;
    logic                  res_found_reg;
    logic [GROUP_W-1:0]    res_owner_reg;
    logic [CONFLICT_W-1:0] res_conflict_reg;
    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic                  out_found_reg;
    logic [GROUP_W-1:0]    out_owner_reg;
    logic [CONFLICT_W-1:0] out_conflict_reg;
    logic [COUNT_W-1:0]    out_covered_reg;

    logic               entry_owned;
    logic               walk_last;
    logic [GROUP_W-1:0] owner_ext;

    logic [SLOT_W-1:0] in_first;
    logic [SLOT_W-1:0] in_last;
    logic [GROUP_W-1:0] in_group;

    assign in_first = in_tdata[SLOT_W-1:0];
    assign in_last  = in_tdata[2*SLOT_W-1:SLOT_W];
    assign in_group = in_tdata[2*SLOT_W+GROUP_W-1:2*SLOT_W];

    assign chk_plus    = chk_reg + 1'b1;
    assign entry_owned = (rd_data_reg != NO_OWNER);
    assign walk_last   = (chk_reg == last_reg);
    assign owner_ext   = GROUP_W'(rd_data_reg);

    // One write port: the clearing sweep or a walk step
    assign wr_en   = cmd.clr_write | cmd.walk_step;
    assign wr_addr = cmd.clr_write ? clr_addr_reg : chk_reg[AW-1:0];
    assign wr_data = cmd.clr_write ? NO_OWNER : group_reg;

    // One read port: the first slot, or the slot after the one being written
    assign rd_en   = cmd.rd_first | (cmd.walk_step & ~walk_last);
    assign rd_addr = cmd.rd_first ? first_reg[AW-1:0] : chk_plus[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            owner_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= owner_mem[rd_addr];
        end
    end

    // Request latch and walk pointer
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_type_reg <= in_tuser;
            first_reg    <= in_first;
            last_reg     <= in_last;
            group_reg    <= in_group[GW-1:0];
        end
        if (cmd.walk_start)
        begin
            chk_reg <= first_reg;
        end
        else if (cmd.walk_step)
        begin
            chk_reg <= chk_plus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            covered_reg  <= '0;
            failed_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clr_write)
            begin
                clr_addr_reg <= (clr_addr_reg == LAST_ADDR) ? '0 : clr_addr_reg + 1'b1;
            end
            if (cmd.clear_state)
            begin
                covered_reg <= '0;
                failed_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.walk_step)
                begin
                    covered_reg <= covered_reg + 1'b1;
                end
                if (cmd.set_fail)
                begin
                    failed_reg <= 1'b1;
                end
            end
        end
    end

    // Result staging
    always_ff @(posedge clk)
    begin
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_status;
            unique case (cmd.res_kind)
                RES_LOOKUP:
                begin
                    res_found_reg    <= entry_owned;
                    res_owner_reg    <= entry_owned ? owner_ext : OUT_NONE;
                    res_conflict_reg <= '0;
                end
                RES_CONFLICT:
                begin
                    res_found_reg    <= 1'b0;
                    res_owner_reg    <= owner_ext;
                    res_conflict_reg <= chk_reg[CONFLICT_W-1:0];
                end
                default:
                begin
                    res_found_reg    <= 1'b0;
                    res_owner_reg    <= OUT_NONE;
                    res_conflict_reg <= '0;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg   <= res_status_reg;
            out_found_reg    <= res_found_reg;
            out_owner_reg    <= res_owner_reg;
            out_conflict_reg <= res_conflict_reg;
            out_covered_reg  <= covered_reg;
        end
    end

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_covered_reg, out_conflict_reg,
                         out_owner_reg, out_found_reg, out_status_reg};

    assign sts.req_type     = req_type_reg;
    assign sts.failed       = failed_reg;
    assign sts.inverted     = (first_reg > last_reg);
    assign sts.beyond       = ({1'b0, last_reg} >= SLOT_LIMIT);
    assign sts.no_owner_grp = (group_reg == NO_OWNER);
    assign sts.lookup_oor   = ({1'b0, first_reg} >= SLOT_LIMIT);
    assign sts.clr_last     = (clr_addr_reg == LAST_ADDR);
    assign sts.entry_owned  = entry_owned;
    assign sts.walk_last    = walk_last;
    assign sts.out_busy     = out_valid_reg & ~out_tready;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (SLOT_W + 1)'(covered_reg) <= SLOT_LIMIT)
        else $error("covered count above slot count");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> (chk_reg <= last_reg && chk_reg >= first_reg))
        else $error("walk wrote outside the requested range");

    a_fail_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(failed_reg) |-> $past(cmd.set_fail))
        else $error("failure flag set without a failing assign");

endmodule

/* src/slot_range_owner_map.sv */
// Top level of the slot range owner map: hash slot to owning group table.
// Depends on srom_pkg, srom_ctrl and srom_dpath.
//
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the request kind
//   (clear, assign range, look up slot), tdata carries first slot, last
//   slot and group. Each request gives exactly one result transfer on the
//   m_axis channel: status, owner found flag, owner group, conflicting slot
//   and the count of owned slots after the request.
// Steps from accept to result valid, then back to ready:
//   plain results (failure, range errors, no-owner group, unused kind): decode, respond
//   lookup: decode, registered table read, respond
//   assign of N slots: decode, walk, respond; the walk writes one table entry a cycle
//   clear: decode, sweep, respond; the table is swept one entry a cycle
// The block works on one request at a time; s_axis_tready is high only
// while it waits for a request. A finished result sits in an output
// register, so the next request is taken while m_axis stalls; that request
// then holds in its response step until the output register drains.
// Reset: the table is swept to "no owner" with s_axis_tready low;
// count and failure flag clear at once.

module slot_range_owner_map
    import srom_pkg::*;
#(
    parameter int SLOT_COUNT        = 16384,
    parameter int GROUP_INDEX_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // first_slot[15:0], last_slot[31:16],
                                                   // group[47:32]
    input  logic [REQ_W-1:0]       s_axis_tuser,   // req_type[1:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // status[2:0], owner_found[3],
                                                   // owner_group[19:4], conflict_slot[33:20],
                                                   // covered_count[48:34], zero pad
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer: owns the request handshake and every step of the work
    srom_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Table memory, walk pointer, count, failure flag, result and output registers
    srom_dpath #(
        .SLOT_COUNT        (SLOT_COUNT),
        .GROUP_INDEX_WIDTH (GROUP_INDEX_WIDTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_tdata   (s_axis_tdata),
        .in_tuser   (s_axis_tuser),
        .out_tready (m_axis_tready),
        .out_tvalid (m_axis_tvalid),
        .out_tdata  (m_axis_tdata),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule
